### hdl/sabe_pkg.sv
// Package: shared types, codes and defaults for the sorted ask book engine.
package sabe_pkg;

	localparam int SABE_DEPTH = 1024;

	localparam int PRICE_W = 24;
	localparam int QTY_W   = 16;
	localparam int POS_W   = 10;
	localparam int SHARE_W = 24;
	localparam int COST_W  = 48;
	localparam int CNT_W   = 11;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_BUY    = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic [QTY_W-1:0]   qty;
	} entry_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_DROP   = 2'd2,
		CELL_HEAD   = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		entry_t   entry;
	} cell_ctrl_t;

endpackage

### hdl/sabe_req_if.sv
// Interface: command channel (valid/ready plus command payload).
interface sabe_req_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   cmd;
	logic [sabe_pkg::PRICE_W-1:0] price;
	logic [sabe_pkg::QTY_W-1:0]   order_size;
	logic [sabe_pkg::POS_W-1:0]   position;
	logic [sabe_pkg::SHARE_W-1:0] shares;

	modport source (output valid, cmd, price, order_size, position, shares, input ready);
	modport sink   (input valid, cmd, price, order_size, position, shares, output ready);
endinterface

### hdl/sabe_rsp_if.sv
// Interface: result channel (valid/ready plus result payload).
interface sabe_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [sabe_pkg::COST_W-1:0] cost;
	logic [1:0]                  status;
	logic [sabe_pkg::CNT_W-1:0]  entry_count;

	modport source (output valid, cost, status, entry_count, input ready);
	modport sink   (input valid, cost, status, entry_count, output ready);
endinterface

### hdl/sabe_cell.sv
// Book cell: one sorted (price, size) entry with insert, drop and head-update moves.
module sabe_cell #(
	parameter int IDX = 0,
	parameter int CW  = 11
) (
	input  logic                 clk,
	input  sabe_pkg::cell_ctrl_t ctrl,
	input  logic [CW-1:0]        count,
	input  logic [CW-1:0]        rm_pos,
	input  sabe_pkg::entry_t     left,
	input  sabe_pkg::entry_t     right,
	input  logic                 prev_le,
	output sabe_pkg::entry_t     entry,
	output logic                 le
);

	localparam logic [CW-1:0] MY_IDX = CW'(IDX);

	sabe_pkg::entry_t entry_q;
	logic             occupied;

	assign occupied = MY_IDX < count;
	assign le       = occupied && (entry_q <= ctrl.entry);
	assign entry    = entry_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			sabe_pkg::CELL_INSERT: begin
				if (!le) begin
					entry_q <= prev_le ? ctrl.entry : left;
				end
			end
			sabe_pkg::CELL_DROP: begin
				if (MY_IDX >= rm_pos) begin
					entry_q <= right;
				end
			end
			sabe_pkg::CELL_HEAD: begin
				if (IDX == 0) begin
					entry_q <= ctrl.entry;
				end
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

endmodule

### hdl/sorted_ask_book_engine.sv
// Top level: ask book held in a row of shifting cells, with command control and buy loop.
//
//   channel | dir | handshake      | payload
//   req     | in  | valid / ready  | cmd, price, order_size, position, shares
//   rsp     | out | valid / ready  | cost, status, entry_count
//
// Add, remove and any command that leaves the book alone complete at the accepting edge:
// all cells compare and shift in parallel.
// Buy steps through the entries it touches in S_BUY, then finishes the cost sum in S_SUM
// (24x16 multiply registered, then 48-bit accumulate).
// Reset clears the entry count and control; cell contents are undefined until written.
// One command is in flight at a time; rsp holds in its output register until taken,
// and req.ready is high in idle while that register is free or being emptied.
module sorted_ask_book_engine #(
	parameter int DEPTH = sabe_pkg::SABE_DEPTH
) (
	input logic         clk,
	input logic         arst_n,
	sabe_req_if.sink    req,
	sabe_rsp_if.source  rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_BUY,
		S_SUM
	} state_t;

	state_t                         state_q;
	logic [CW-1:0]                  count_q;
	logic [sabe_pkg::SHARE_W-1:0]   want_q;
	logic [sabe_pkg::COST_W-1:0]    cost_q;
	logic [39:0]                    prod_s1;
	logic                           prod_v_s1;

	logic                           rsp_valid_q;
	logic [sabe_pkg::COST_W-1:0]    rsp_cost_q;
	logic [1:0]                     rsp_status_q;
	logic [sabe_pkg::CNT_W-1:0]     rsp_count_q;

	sabe_pkg::entry_t               cell_entry [DEPTH];
	logic                           cell_le    [DEPTH];
	sabe_pkg::cell_ctrl_t           ctrl;
	logic [CW-1:0]                  rm_pos;

	logic                           accept;
	logic                           full;
	logic [CW-1:0]                  last;
	logic [CW+9:0]                  pos_w;
	logic [CW+9:0]                  last_w;
	logic [CW-1:0]                  pos_clamp;
	sabe_pkg::entry_t               head;
	logic [sabe_pkg::QTY_W-1:0]     take;
	logic                           head_empties;
	logic [sabe_pkg::SHARE_W-1:0]   want_next;
	logic [39:0]                    prod_c;

	function automatic logic [sabe_pkg::CNT_W-1:0] cnt11(input logic [CW-1:0] c);
		logic [CW+10:0] w;
		w = {11'b0, c};
		return w[10:0];
	endfunction

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign full      = count_q == CW'(DEPTH);
	assign last      = count_q - 1'b1;
	assign pos_w     = {{CW{1'b0}}, req.position};
	assign last_w    = {10'b0, last};
	assign pos_clamp = (pos_w > last_w) ? last : pos_w[CW-1:0];

	assign head         = cell_entry[0];
	assign take         = (want_q < {8'b0, head.qty}) ? want_q[sabe_pkg::QTY_W-1:0] : head.qty;
	assign head_empties = take == head.qty;
	assign want_next    = want_q - {8'b0, take};
	assign prod_c       = {24'b0, take} * {16'b0, head.price};

	always_comb begin
		ctrl.op           = sabe_pkg::CELL_HOLD;
		ctrl.entry.price  = req.price;
		ctrl.entry.qty    = req.order_size;
		rm_pos            = pos_clamp;
		if (accept) begin
			case (req.cmd)
				sabe_pkg::CMD_ADD: begin
					if (!full) begin
						ctrl.op = sabe_pkg::CELL_INSERT;
					end
				end
				sabe_pkg::CMD_REMOVE: begin
					if (count_q != '0) begin
						ctrl.op = sabe_pkg::CELL_DROP;
					end
				end
				default: begin
					ctrl.op = sabe_pkg::CELL_HOLD;
				end
			endcase
		end else if (state_q == S_BUY) begin
			if (head_empties) begin
				ctrl.op = sabe_pkg::CELL_DROP;
				rm_pos  = '0;
			end else begin
				ctrl.op          = sabe_pkg::CELL_HEAD;
				ctrl.entry.price = head.price;
				ctrl.entry.qty   = head.qty - take;
			end
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		sabe_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk     (clk),
			.ctrl    (ctrl),
			.count   (count_q),
			.rm_pos  (rm_pos),
			.left    (cell_entry[(i == 0) ? 0 : i - 1]),
			.right   (cell_entry[(i == DEPTH - 1) ? i : i + 1]),
			.prev_le ((i == 0) ? 1'b1 : cell_le[(i == 0) ? 0 : i - 1]),
			.entry   (cell_entry[i]),
			.le      (cell_le[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			prod_v_s1    <= 1'b0;
			rsp_valid_q  <= 1'b0;
			want_q       <= '0;
			cost_q       <= '0;
			prod_s1      <= '0;
			rsp_cost_q   <= '0;
			rsp_status_q <= sabe_pkg::ST_OK;
			rsp_count_q  <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			prod_v_s1 <= 1'b0;
			if (prod_v_s1) begin
				cost_q <= cost_q + {8'b0, prod_s1};
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						rsp_cost_q   <= '0;
						rsp_status_q <= sabe_pkg::ST_OK;
						rsp_count_q  <= cnt11(count_q);
						rsp_valid_q  <= 1'b1;
						case (req.cmd)
							sabe_pkg::CMD_ADD: begin
								if (full) begin
									rsp_status_q <= sabe_pkg::ST_FULL;
								end else begin
									count_q     <= count_q + 1'b1;
									rsp_count_q <= cnt11(count_q + 1'b1);
								end
							end
							sabe_pkg::CMD_REMOVE: begin
								if (count_q == '0) begin
									rsp_status_q <= sabe_pkg::ST_EMPTY;
								end else begin
									count_q     <= last;
									rsp_count_q <= cnt11(last);
								end
							end
							sabe_pkg::CMD_BUY: begin
								if (req.shares != '0 && count_q != '0) begin
									rsp_valid_q <= 1'b0;
									want_q      <= req.shares;
									cost_q      <= '0;
									state_q     <= S_BUY;
								end
							end
							default: begin
								rsp_status_q <= sabe_pkg::ST_OK;
							end
						endcase
					end
				end
				S_BUY: begin
					prod_s1   <= prod_c;
					prod_v_s1 <= 1'b1;
					want_q    <= want_next;
					if (head_empties) begin
						count_q <= last;
					end
					if (want_next == '0 || (head_empties && count_q == CW'(1))) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					rsp_cost_q   <= cost_q + {8'b0, prod_s1};
					rsp_status_q <= sabe_pkg::ST_OK;
					rsp_count_q  <= cnt11(count_q);
					rsp_valid_q  <= 1'b1;
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.cost        = rsp_cost_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.entry_count = rsp_count_q;

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_buy_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BUY) |-> (want_q != '0 && count_q != '0))
		else $error("buy loop running with nothing to do");

	a_product_from_buy: assert property (@(posedge clk) disable iff (!arst_n)
		prod_v_s1 |-> $past(state_q == S_BUY))
		else $error("product valid outside buy loop");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && count_q >= CW'(2)) |-> !(cell_entry[1] < cell_entry[0]))
		else $error("book head out of order");

	a_sum_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUM) |=> (rsp_valid_q && state_q == S_IDLE))
		else $error("buy finished without result");

endmodule

### dv/tb_top.sv
// Testbench for the sorted ask book engine: order stream, book predictor and reply checks.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BOOK_DEPTH = sabe_pkg::SABE_DEPTH;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 300;

	typedef logic [sabe_pkg::PRICE_W-1:0] price_t;
	typedef logic [sabe_pkg::QTY_W-1:0]   qty_t;
	typedef logic [sabe_pkg::POS_W-1:0]   pos_t;
	typedef logic [sabe_pkg::SHARE_W-1:0] shares_t;
	typedef logic [sabe_pkg::COST_W-1:0]  cost_t;
	typedef logic [sabe_pkg::CNT_W-1:0]   cnt_t;

	typedef struct {
		cost_t      cost;
		logic [1:0] status;
		cnt_t       count;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n;

	sabe_req_if order_ch ();
	sabe_rsp_if reply_ch ();

	sorted_ask_book_engine u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (order_ch),
		.rsp    (reply_ch)
	);

	always #10 clk = ~clk;

	sabe_pkg::entry_t ask_book[$];
	reply_t           expected_replies[$];
	int unsigned      mismatch_count = 0;
	int unsigned      hold_requests = 0;
	bit               sender_gaps = 1'b1;
	bit               receiver_gaps = 1'b1;

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// book update for one accepted order, returns the reply it should produce
	function automatic reply_t book_apply(logic [1:0] cmd, price_t price,
			qty_t size, pos_t position, shares_t shares);
		reply_t r;
		sabe_pkg::entry_t e;
		int unsigned j;
		int unsigned idx;
		shares_t want;
		qty_t take;
		r.cost = '0;
		r.status = sabe_pkg::ST_OK;
		case (cmd)
			sabe_pkg::CMD_ADD: begin
				if (ask_book.size() >= BOOK_DEPTH) begin
					r.status = sabe_pkg::ST_FULL;
				end else begin
					j = 0;
					while (j < ask_book.size() && (ask_book[j].price < price ||
							(ask_book[j].price == price && ask_book[j].qty <= size)))
						j++;
					e.price = price;
					e.qty = size;
					ask_book.insert(j, e);
				end
			end
			sabe_pkg::CMD_REMOVE: begin
				if (ask_book.size() == 0) begin
					r.status = sabe_pkg::ST_EMPTY;
				end else begin
					idx = {22'b0, position};
					if (idx > ask_book.size() - 1)
						idx = ask_book.size() - 1;
					ask_book.delete(idx);
				end
			end
			sabe_pkg::CMD_BUY: begin
				want = shares;
				while (want != '0 && ask_book.size() != 0) begin
					take = (want < shares_t'(ask_book[0].qty)) ?
						want[sabe_pkg::QTY_W-1:0] : ask_book[0].qty;
					want = want - shares_t'(take);
					r.cost = r.cost + cost_t'(take) * cost_t'(ask_book[0].price);
					ask_book[0].qty = ask_book[0].qty - take;
					if (ask_book[0].qty == '0)
						ask_book.delete(0);
				end
			end
			default: begin
			end
		endcase
		r.count = cnt_t'(ask_book.size());
		return r;
	endfunction

	task automatic place_order(logic [1:0] cmd, price_t price,
			qty_t size, pos_t position, shares_t shares);
		int unsigned gap;
		gap = sender_gaps ? pick_gap() : 0;
		if (gap != 0) begin
			order_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		order_ch.valid      <= 1'b1;
		order_ch.cmd        <= cmd;
		order_ch.price      <= price;
		order_ch.order_size <= size;
		order_ch.position   <= position;
		order_ch.shares     <= shares;
		do
			@(posedge clk);
		while (!(order_ch.valid === 1'b1 && order_ch.ready === 1'b1));
		expected_replies.insert(expected_replies.size(),
			book_apply(cmd, price, size, position, shares));
	endtask

	task automatic settle_book();
		order_ch.valid <= 1'b0;
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic price_t rand_price();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4: return price_t'($urandom_range(0, 15));
			default: return price_t'($urandom());
		endcase
	endfunction

	function automatic qty_t rand_size();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4: return qty_t'($urandom_range(1, 8));
			default: return qty_t'($urandom());
		endcase
	endfunction

	function automatic shares_t rand_shares();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return '1;
			2, 3, 4, 5: return shares_t'($urandom_range(1, 20));
			6, 7, 8: return shares_t'($urandom_range(1, 200000));
			9, 10: return shares_t'($urandom_range(1, 2000000));
			default: return shares_t'($urandom());
		endcase
	endfunction

	function automatic pos_t rand_position();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3, 4, 5: return pos_t'($urandom_range(0, ask_book.size()));
			default: return pos_t'($urandom());
		endcase
	endfunction

	task automatic random_order();
		int unsigned r;
		bit crowded;
		logic [1:0] cmd;
		r = $urandom_range(0, 99);
		crowded = ask_book.size() > 48;
		if (r < 3)
			cmd = CMD_UNUSED;
		else if (r < (crowded ? 25 : 55))
			cmd = sabe_pkg::CMD_ADD;
		else if (r < (crowded ? 55 : 72))
			cmd = sabe_pkg::CMD_REMOVE;
		else
			cmd = sabe_pkg::CMD_BUY;
		place_order(cmd, rand_price(), rand_size(), rand_position(), rand_shares());
	endtask

	task automatic test_directed();
		place_order(sabe_pkg::CMD_REMOVE, '1, '1, 10'h3FF, '1);
		place_order(sabe_pkg::CMD_BUY, '1, '1, '1, '0);
		place_order(sabe_pkg::CMD_BUY, '0, '0, '0, '1);
		place_order(CMD_UNUSED, '1, '1, '1, '1);
		place_order(sabe_pkg::CMD_ADD, 24'hFFFFFF, 16'hFFFF, '0, '0);
		place_order(sabe_pkg::CMD_ADD, 24'd0, 16'd0, '1, '1);
		place_order(sabe_pkg::CMD_ADD, 24'd0, 16'd1, '0, '0);
		place_order(sabe_pkg::CMD_ADD, 24'd100, 16'd10, '0, '0);
		place_order(sabe_pkg::CMD_ADD, 24'd100, 16'd10, '0, '0);
		place_order(sabe_pkg::CMD_ADD, 24'd100, 16'd5, '0, '0);
		place_order(CMD_UNUSED, '0, '0, '0, '0);
		place_order(sabe_pkg::CMD_REMOVE, '0, '0, 10'h3FF, '0);
		place_order(sabe_pkg::CMD_BUY, '0, '0, '0, 24'd1);
		place_order(sabe_pkg::CMD_BUY, '1, '1, '1, 24'd0);
		place_order(sabe_pkg::CMD_BUY, '0, '0, '0, 24'd12);
		place_order(sabe_pkg::CMD_ADD, 24'hFFFFFF, 16'hFFFF, '0, '0);
		place_order(sabe_pkg::CMD_REMOVE, '0, '0, 10'd0, '0);
		place_order(sabe_pkg::CMD_ADD, 24'h800000, 16'h8000, '0, '0);
		place_order(sabe_pkg::CMD_BUY, '0, '0, '0, 24'hFFFFFF);
		place_order(sabe_pkg::CMD_REMOVE, '0, '0, 10'd5, '0);
		settle_book();
	endtask

	task automatic test_random_mix(int unsigned n_orders);
		for (int unsigned k = 0; k < 4; k++) begin
			sender_gaps = (k == 0 || k == 2);
			receiver_gaps = (k == 0 || k == 3);
			repeat (n_orders / 4) random_order();
		end
		sender_gaps = 1'b1;
		receiver_gaps = 1'b1;
		settle_book();
	endtask

	task automatic test_backpressure();
		hold_requests++;
		sender_gaps = 1'b0;
		repeat (24) random_order();
		sender_gaps = 1'b1;
		settle_book();
	endtask

	task automatic test_full_book();
		while (ask_book.size() < BOOK_DEPTH)
			place_order(sabe_pkg::CMD_ADD, rand_price(), rand_size(), rand_position(),
				rand_shares());
		repeat (3)
			place_order(sabe_pkg::CMD_ADD, rand_price(), rand_size(), rand_position(),
				rand_shares());
		place_order(sabe_pkg::CMD_REMOVE, rand_price(), rand_size(), 10'h3FF, rand_shares());
		place_order(sabe_pkg::CMD_ADD, 24'hFFFFFF, 16'hFFFF, '0, '0);
		place_order(sabe_pkg::CMD_ADD, 24'd0, 16'd0, '0, '0);
		place_order(CMD_UNUSED, rand_price(), rand_size(), rand_position(), rand_shares());
		while (ask_book.size() != 0)
			place_order(sabe_pkg::CMD_BUY, rand_price(), rand_size(), rand_position(),
				24'hFFFFFF);
		place_order(sabe_pkg::CMD_REMOVE, '0, '0, '0, '0);
		settle_book();
	endtask

	initial begin
		arst_n              <= 1'b0;
		order_ch.valid      <= 1'b0;
		order_ch.cmd        <= sabe_pkg::CMD_ADD;
		order_ch.price      <= '0;
		order_ch.order_size <= '0;
		order_ch.position   <= '0;
		order_ch.shares     <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_mix(440);
		test_backpressure();
		test_full_book();
		test_random_mix(60);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS sorted_ask_book_engine");
		else
			$display("FAIL sorted_ask_book_engine");
		$finish;
	end

	initial begin : reply_taker
		int unsigned stall_left;
		int unsigned hold_left;
		int unsigned holds_done;
		int unsigned gap;
		stall_left = 0;
		hold_left = 0;
		holds_done = 0;
		reply_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (holds_done != hold_requests) begin
				holds_done = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				reply_ch.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				reply_ch.ready <= 1'b0;
			end else begin
				gap = receiver_gaps ? pick_gap() : 0;
				if (gap == 0) begin
					reply_ch.ready <= 1'b1;
				end else begin
					reply_ch.ready <= 1'b0;
					stall_left = gap - 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		reply_t exp_r;
		if (arst_n === 1'b1 && reply_ch.valid === 1'b1 && reply_ch.ready === 1'b1) begin
			if (expected_replies.size() == 0) begin
				$error("unexpected reply: cost %0d status %0d entry_count %0d",
					reply_ch.cost, reply_ch.status, reply_ch.entry_count);
				mismatch_count++;
			end else begin
				exp_r = expected_replies.pop_front();
				if (reply_ch.cost !== exp_r.cost) begin
					$error("cost: expected %0d, got %0d", exp_r.cost, reply_ch.cost);
					mismatch_count++;
				end
				if (reply_ch.status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, reply_ch.status);
					mismatch_count++;
				end
				if (reply_ch.entry_count !== exp_r.count) begin
					$error("entry_count: expected %0d, got %0d", exp_r.count,
						reply_ch.entry_count);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#40ms;
		$display("FAIL sorted_ask_book_engine");
		$finish;
	end

endmodule
